[design/pfr_pkg.sv]
`default_nettype none

package pfr_pkg;

    // Panel geometry.
    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;

    // Store organization: one byte holds eight vertical pixels of one page.
    localparam int PAGE_COUNT     = PANEL_HEIGHT / 8;
    localparam int STORE_BYTES    = PANEL_WIDTH * PAGE_COUNT;
    localparam int PAIRS_PER_PAGE = 3 + PANEL_WIDTH;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int PAGE_W         = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int COL_W          = $clog2(PANEL_WIDTH);
    localparam int SLOT_W         = $clog2(PAIRS_PER_PAGE);

    // Operation codes of an input item.
    localparam logic [1:0] OP_DRAW    = 2'd0;
    localparam logic [1:0] OP_CLEAR   = 2'd1;
    localparam logic [1:0] OP_REFRESH = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PAGE_ADDR = 2'd0;
    localparam logic [1:0] CFG_COL_UPPER = 2'd1;
    localparam logic [1:0] CFG_COL_LOWER = 2'd2;

    // Bus prefixes for the panel stream.
    localparam logic [7:0] CTRL_COMMAND = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;

    // Refresh slots within a page.
    localparam logic [SLOT_W-1:0] SLOT_PAGE_ADDR = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_COL_UPPER = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_COL_LOWER = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SLOT_LAST      = SLOT_W'(PAIRS_PER_PAGE - 1);
    localparam logic [PAGE_W-1:0] PAGE_LAST      = PAGE_W'(PAGE_COUNT - 1);

endpackage

`default_nettype wire

[design/page_framebuffer_refresh.sv]
// Monochrome page framebuffer with a panel refresh stream.
// Input channel (i_in_valid / o_in_ready) takes items: draw one pixel, clear
// the store, or emit the next (control, payload) pair of the frame stream.
// Output channel (o_out_valid / i_out_ready) carries one pair per refresh
// item; draw and clear items give no output. Configuration writes through
// i_cfg_we / i_cfg_index / i_cfg_data take effect on the next clock edge.
// For a draw or refresh item the store is read at the edge that accepts the
// item; at the next edge a draw byte is modified and written back, while a
// refresh byte is loaded into the output register once that register is
// free. The store has a registered read port. A refresh pair passes through
// the read register and then the output register on its way to the output.
// A clear item, and reset, sweep the store at one byte per cycle, so the
// block takes no item until all STORE_BYTES bytes (1024 by default) are clear.
// Reset also restores the command registers and rewinds the frame position.
// When the receiver stalls, the finished pair waits in the output register
// while other items keep being accepted; a refresh item that arrives then
// holds in its execute state until the register is free.
`default_nettype none

module page_framebuffer_refresh (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_operation,
    input  wire logic [7:0] i_x,
    input  wire logic [6:0] i_y,
    input  wire logic       i_pixel_on,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_control_byte,
    output logic [7:0]      o_payload,
    output logic            o_frame_last,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    localparam int AW = pfr_pkg::ADDR_W;

    logic [1:0]                 r_state, n_state;
    logic [AW-1:0]              r_clr_addr;
    logic [AW-1:0]              r_rd_addr, n_rd_addr;
    logic [7:0]                 r_rdata;
    logic [1:0]                 r_op;
    logic [2:0]                 r_bit;
    logic                       r_on;
    logic                       r_hit;
    logic [pfr_pkg::PAGE_W-1:0] r_page;
    logic [pfr_pkg::SLOT_W-1:0] r_slot;
    logic [7:0]                 r_cmd_page, r_cmd_upper, r_cmd_lower;
    logic                       r_out_valid;
    logic [7:0]                 r_out_ctrl, r_out_payload;
    logic                       r_out_last;

    logic [7:0] mem [pfr_pkg::STORE_BYTES];

    logic                       accept;
    logic                       hit;
    logic [pfr_pkg::COL_W-1:0]  ref_col;
    logic [pfr_pkg::PAGE_W-1:0] draw_page;
    logic                       out_free;
    logic                       emit;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [7:0]                 mem_wdata;
    logic [7:0]                 bit_mask;
    logic [7:0]                 pay;
    logic [7:0]                 ctrl;
    logic                       frame_end;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign accept       = i_in_valid && o_in_ready;
    assign out_free     = !r_out_valid || i_out_ready;
    assign emit         = (r_state == ST_EXEC) && (r_op == pfr_pkg::OP_REFRESH) && out_free;

    // Pixel hit test; rows of an incomplete last page lie in no page.
    assign hit = ({1'b0, i_x} < 9'(pfr_pkg::PANEL_WIDTH)) &&
                 ({1'b0, i_y} < 8'(pfr_pkg::PAGE_COUNT * 8));

    assign draw_page = pfr_pkg::PAGE_W'(i_y >> 3);
    assign ref_col   = pfr_pkg::COL_W'(r_slot - pfr_pkg::SLOT_W'(3));

    // Read address: taken from the new item at accept, else held.
    always_comb begin
        n_rd_addr = r_rd_addr;
        if (accept) begin
            if (i_operation == pfr_pkg::OP_REFRESH) begin
                n_rd_addr = AW'(AW'(r_page) * AW'(pfr_pkg::PANEL_WIDTH) + AW'(ref_col));
            end else begin
                n_rd_addr = AW'(AW'(draw_page) * AW'(pfr_pkg::PANEL_WIDTH) +
                                AW'(i_x[pfr_pkg::COL_W-1:0]));
            end
        end
    end

    // Write port: clearing sweep or the pixel read-modify-write.
    assign bit_mask = 8'(1) << r_bit;
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_rd_addr;
        mem_wdata = r_on ? (r_rdata | bit_mask) : (r_rdata & ~bit_mask);
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = 8'h00;
        end else if (r_state == ST_EXEC && r_op == pfr_pkg::OP_DRAW && r_hit) begin
            mem_we = 1'b1;
        end
    end

    // Frame store with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[n_rd_addr];
    end

    // Refresh pair for the current position.
    always_comb begin
        ctrl = pfr_pkg::CTRL_COMMAND;
        case (r_slot)
            pfr_pkg::SLOT_PAGE_ADDR: pay = r_cmd_page | 8'(r_page);
            pfr_pkg::SLOT_COL_UPPER: pay = r_cmd_upper;
            pfr_pkg::SLOT_COL_LOWER: pay = r_cmd_lower;
            default: begin
                ctrl = pfr_pkg::CTRL_DATA;
                pay  = r_rdata;
            end
        endcase
    end
    assign frame_end = (r_page == pfr_pkg::PAGE_LAST) && (r_slot == pfr_pkg::SLOT_LAST);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(pfr_pkg::STORE_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_operation == pfr_pkg::OP_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else if (i_operation == pfr_pkg::OP_DRAW ||
                                 i_operation == pfr_pkg::OP_REFRESH) begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (r_op != pfr_pkg::OP_REFRESH || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_rd_addr   <= '0;
            r_page      <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
            r_cmd_page  <= 8'd176;
            r_cmd_upper <= 8'd16;
            r_cmd_lower <= 8'd0;
        end else begin
            r_state   <= n_state;
            r_rd_addr <= n_rd_addr;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end else begin
                r_clr_addr <= '0;
            end
            // Frame position advances with each emitted pair.
            if (emit) begin
                if (frame_end) begin
                    r_page <= '0;
                    r_slot <= '0;
                end else if (r_slot == pfr_pkg::SLOT_LAST) begin
                    r_page <= r_page + pfr_pkg::PAGE_W'(1);
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + pfr_pkg::SLOT_W'(1);
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // Command registers; unknown indexes are ignored.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pfr_pkg::CFG_PAGE_ADDR: r_cmd_page  <= i_cfg_data;
                    pfr_pkg::CFG_COL_UPPER: r_cmd_upper <= i_cfg_data;
                    pfr_pkg::CFG_COL_LOWER: r_cmd_lower <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Item and output payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_operation;
            r_bit <= i_y[2:0];
            r_on  <= i_pixel_on;
            r_hit <= hit;
        end
        if (emit) begin
            r_out_ctrl    <= ctrl;
            r_out_payload <= pay;
            r_out_last    <= frame_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_control_byte = r_out_ctrl;
    assign o_payload      = r_out_payload;
    assign o_frame_last   = r_out_last;

endmodule

`default_nettype wire
